// ===== src/stpg_pkg.sv =====
// ============================================================================
// Sine tone PCM generator package
// Widths, configuration codes and fixed-point constants of the tone generator.
// ============================================================================
package stpg_pkg;

    // Field and register widths.
    localparam int IDX_W      = 16;
    localparam int PHASE_W    = 32;
    localparam int WORD_W     = 32;
    localparam int CHAN_W     = 3;
    localparam int PER_CFG_W  = 17;
    localparam int FMT_W      = 3;
    localparam int CCNT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_PERIOD   = 65536;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANS  = 2'd2;

    // Configuration reset values.
    localparam logic [PER_CFG_W-1:0] RST_PERIOD = 17'd480;
    localparam logic [FMT_W-1:0]     RST_FORMAT = 3'd1;
    localparam logic [CCNT_W-1:0]    RST_CHANS  = 4'd2;

    // Sample format codes.
    localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

    // Phase divider: remainder steps per pipeline stage.
    localparam int DIV_STEPS = 4;
    localparam int DIV_STG   = (IDX_W + PHASE_W) / DIV_STEPS;

    // Q1.31 constants.
    localparam logic [31:0] HALF_PI_Q31 = 32'hC90FDAA2;
    localparam logic [31:0] ONE_Q31     = 32'h80000000;
    localparam logic [30:0] MAX_Q31     = 31'h7FFFFFFF;

    // Taylor series terms, highest first: divisors k*(k+1) and their reciprocals.
    localparam int NIT      = 7;
    localparam int RECIP_SH = 34;
    localparam logic [7:0] ITER_DIV [NIT] = '{
        8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [31:0] ITER_RECIP [NIT] = '{
        32'((64'd1 << RECIP_SH) / 64'd210),
        32'((64'd1 << RECIP_SH) / 64'd156),
        32'((64'd1 << RECIP_SH) / 64'd110),
        32'((64'd1 << RECIP_SH) / 64'd72),
        32'((64'd1 << RECIP_SH) / 64'd42),
        32'((64'd1 << RECIP_SH) / 64'd20),
        32'((64'd1 << RECIP_SH) / 64'd6)
    };

endpackage

// ===== src/sine_tone_pcm_generator_unit.sv =====
// ============================================================================
// Sine tone PCM generator
// Turns a sample position into a sine sample in the chosen PCM format and
// sends one copy of it per channel.
// ============================================================================
// The block accepts one sample position per clock cycle while not stalled;
// its path to the output register is 12 stages of a four-bit-per-stage
// phase divider, 3 stages of angle folding and squaring, 21 stages for the
// seven Taylor terms (multiply, reciprocal multiply, correction), one stage
// for the final product and 3 stages of format encoding. The output
// register sends one channel copy per cycle while m_axis_tready is high, so
// an item with C channels holds the output until its C copies have left;
// the whole pipeline and the input stall whenever a finished item in the
// last encoding stage waits behind an output that is still busy.
module sine_tone_pcm_generator_unit
    import stpg_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_PERIOD   = DEF_MAX_PERIOD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IDX_W-1:0]      s_axis_tdata,  // [15:0] sample_index
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WORD_W-1:0]     m_axis_tdata,  // [31:0] sample_word
    output logic [CHAN_W-1:0]     m_axis_tuser,  // [2:0] channel
    output logic                  m_axis_tlast
);

    localparam int PW = $clog2(MAX_PERIOD) + 1;
    localparam int SW = (PW > PER_CFG_W) ? PW : PER_CFG_W;
    localparam logic [SW-1:0] MAX_PER_S = SW'(MAX_PERIOD);
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int CX = (CW > CCNT_W) ? CW : CCNT_W;
    localparam logic [CX-1:0] MAX_CH_X = CX'(MAX_CHANNELS);

    // Configuration.
    logic [PER_CFG_W-1:0] r_period;
    logic [FMT_W-1:0]     r_format;
    logic [CCNT_W-1:0]    r_chcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_format <= RST_FORMAT;
            r_chcnt  <= RST_CHANS;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PERIOD) r_period <= i_cfg_data;
            if (i_cfg_index == CFG_FORMAT) r_format <= i_cfg_data[FMT_W-1:0];
            if (i_cfg_index == CFG_CHANS)  r_chcnt  <= i_cfg_data[CCNT_W-1:0];
        end
    end

    logic [SW-1:0] w_per_s;
    logic [PW-1:0] w_per;
    logic [CX-1:0] w_ch_x;
    logic [CW-1:0] w_chans;

    assign w_per_s = (SW'(r_period) > MAX_PER_S) ? MAX_PER_S : SW'(r_period);
    assign w_per   = PW'(w_per_s);
    assign w_ch_x  = (CX'(r_chcnt) > MAX_CH_X) ? MAX_CH_X : CX'(r_chcnt);
    assign w_chans = CW'(w_ch_x);

    // Global pipeline advance.
    logic w_adv;
    logic w_free;
    logic r_f3_v;

    assign w_adv         = !r_f3_v || w_free;
    assign s_axis_tready = w_adv;

    // ---------------- Phase divider: floor(n * 2^32 / per) mod 2^32 --------
    logic [DIV_STG-1:0] r_dv_v;
    logic [PW-1:0]      r_dv_rem [DIV_STG];
    logic [IDX_W-1:0]   r_dv_num [DIV_STG];
    logic [PHASE_W-1:0] r_dv_quo [DIV_STG];

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        logic               w_v_in;
        logic [PW-1:0]      w_rem_in;
        logic [IDX_W-1:0]   w_num_in;
        logic [PHASE_W-1:0] w_quo_in;
        logic [PW-1:0]      w_rem;
        logic [IDX_W-1:0]   w_num;
        logic [PHASE_W-1:0] w_quo;
        logic [PW:0]        w_ext;
        logic               w_qb;

        if (g == 0) begin : g_first
            assign w_v_in   = s_axis_tvalid;
            assign w_rem_in = '0;
            assign w_num_in = s_axis_tdata;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_v_in   = r_dv_v[g-1];
            assign w_rem_in = r_dv_rem[g-1];
            assign w_num_in = r_dv_num[g-1];
            assign w_quo_in = r_dv_quo[g-1];
        end

        // Restoring division; quotient bits above bit 31 fall off the top,
        // which is the wrap of the phase.
        always_comb begin
            w_rem = w_rem_in;
            w_num = w_num_in;
            w_quo = w_quo_in;
            w_ext = '0;
            w_qb  = 1'b0;
            for (int s = 0; s < DIV_STEPS; s++) begin
                w_ext = {w_rem, w_num[IDX_W-1]};
                if (w_ext >= {1'b0, w_per}) begin
                    w_ext = w_ext - {1'b0, w_per};
                    w_qb  = 1'b1;
                end else begin
                    w_qb  = 1'b0;
                end
                w_rem = w_ext[PW-1:0];
                w_num = {w_num[IDX_W-2:0], 1'b0};
                w_quo = {w_quo[PHASE_W-2:0], w_qb};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[g] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[g] <= w_rem;
                r_dv_num[g] <= w_num;
                r_dv_quo[g] <= w_quo;
            end
        end
    end

    // ---------------- Quarter-wave fold, angle scaling, square -------------
    logic [PHASE_W-1:0] w_phase;
    logic [30:0]        w_a;
    logic [62:0]        w_xp;
    logic [63:0]        w_x2p;

    logic        r_a_v,  r_x_v,  r_q_v;
    logic [30:0] r_a_a;
    logic        r_a_neg, r_x_neg, r_q_neg;
    logic [31:0] r_x_x,  r_q_x;
    logic [32:0] r_q_x2;

    // A zero period gives phase zero.
    assign w_phase = (w_per == '0) ? '0 : r_dv_quo[DIV_STG-1];
    assign w_a     = w_phase[30] ? (31'h40000000 - {1'b0, w_phase[29:0]})
                                 : {1'b0, w_phase[29:0]};
    assign w_xp    = 63'(r_a_a) * 63'(HALF_PI_Q31);
    assign w_x2p   = 64'(r_x_x) * 64'(r_x_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_x_v <= 1'b0;
            r_q_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= r_dv_v[DIV_STG-1];
            r_x_v <= r_a_v;
            r_q_v <= r_x_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_a   <= w_a;
            r_a_neg <= w_phase[31];
            r_x_x   <= w_xp[61:30];
            r_x_neg <= r_a_neg;
            r_q_x   <= r_x_x;
            r_q_x2  <= w_x2p[63:31];
            r_q_neg <= r_x_neg;
        end
    end

    // ---------------- Taylor terms: t = 1 - x^2 * t / (k*(k+1)) ------------
    logic [NIT-1:0] r_im_v, r_ir_v, r_ic_v;
    logic [31:0]    r_im_x [NIT];
    logic [32:0]    r_im_x2 [NIT];
    logic [32:0]    r_im_p [NIT];
    logic           r_im_neg [NIT];
    logic [31:0]    r_ir_x [NIT];
    logic [32:0]    r_ir_x2 [NIT];
    logic [32:0]    r_ir_p [NIT];
    logic [30:0]    r_ir_qe [NIT];
    logic           r_ir_neg [NIT];
    logic [31:0]    r_ic_x [NIT];
    logic [32:0]    r_ic_x2 [NIT];
    logic [31:0]    r_ic_t [NIT];
    logic           r_ic_neg [NIT];

    for (genvar i = 0; i < NIT; i++) begin : g_iter
        logic        w_v_in;
        logic [31:0] w_x_in;
        logic [32:0] w_x2_in;
        logic [31:0] w_t_in;
        logic        w_neg_in;
        logic [64:0] w_pp;
        logic [64:0] w_rp;
        logic [39:0] w_r;
        logic [31:0] w_q;

        if (i == 0) begin : g_first
            assign w_v_in   = r_q_v;
            assign w_x_in   = r_q_x;
            assign w_x2_in  = r_q_x2;
            assign w_t_in   = ONE_Q31;
            assign w_neg_in = r_q_neg;
        end else begin : g_next
            assign w_v_in   = r_ic_v[i-1];
            assign w_x_in   = r_ic_x[i-1];
            assign w_x2_in  = r_ic_x2[i-1];
            assign w_t_in   = r_ic_t[i-1];
            assign w_neg_in = r_ic_neg[i-1];
        end

        assign w_pp = 65'(w_x2_in) * 65'(w_t_in);
        // The reciprocal estimate is exact or one low; one compare fixes it.
        assign w_rp = 65'(r_im_p[i]) * 65'(ITER_RECIP[i]);
        assign w_r  = 40'(r_ir_p[i]) - 40'(r_ir_qe[i]) * 40'(ITER_DIV[i]);
        assign w_q  = 32'(r_ir_qe[i]) + ((w_r >= 40'(ITER_DIV[i])) ? 32'd1 : 32'd0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_im_v[i] <= 1'b0;
                r_ir_v[i] <= 1'b0;
                r_ic_v[i] <= 1'b0;
            end else if (w_adv) begin
                r_im_v[i] <= w_v_in;
                r_ir_v[i] <= r_im_v[i];
                r_ic_v[i] <= r_ir_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_im_x[i]   <= w_x_in;
                r_im_x2[i]  <= w_x2_in;
                r_im_p[i]   <= w_pp[63:31];
                r_im_neg[i] <= w_neg_in;
                r_ir_x[i]   <= r_im_x[i];
                r_ir_x2[i]  <= r_im_x2[i];
                r_ir_p[i]   <= r_im_p[i];
                r_ir_qe[i]  <= w_rp[64:RECIP_SH];
                r_ir_neg[i] <= r_im_neg[i];
                r_ic_x[i]   <= r_ir_x[i];
                r_ic_x2[i]  <= r_ir_x2[i];
                r_ic_t[i]   <= ONE_Q31 - w_q;
                r_ic_neg[i] <= r_ir_neg[i];
            end
        end
    end

    // ---------------- Sine magnitude ---------------------------------------
    logic [63:0] w_sp;
    logic [30:0] w_mag;
    logic        r_s_v;
    logic [30:0] r_s_mag;
    logic        r_s_neg;

    assign w_sp  = 64'(r_ic_x[NIT-1]) * 64'(r_ic_t[NIT-1]);
    assign w_mag = (w_sp[63:31] > 33'(MAX_Q31)) ? MAX_Q31 : w_sp[61:31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (w_adv) begin
            r_s_v <= r_ic_v[NIT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_mag <= w_mag;
            r_s_neg <= r_ic_neg[NIT-1] && (w_mag != '0);
        end
    end

    // ---------------- Format encoding --------------------------------------
    logic [30:0] w_maxv;
    logic [61:0] w_ip;
    logic [4:0]  w_pos;
    logic [30:0] w_norm;
    logic [31:0] w_int;
    logic [24:0] w_mant25;
    logic [7:0]  w_exp;
    logic [22:0] w_frac;
    logic [31:0] w_flt;
    logic [31:0] w_word;

    logic        r_f1_v, r_f2_v;
    logic [30:0] r_f1_m, r_f1_mag;
    logic [4:0]  r_f1_pos, r_f2_pos;
    logic        r_f1_neg, r_f2_neg;
    logic [31:0] r_f2_int;
    logic [23:0] r_f2_mant;
    logic        r_f2_rnd, r_f2_zero;
    logic [31:0] r_f3_word;

    always_comb begin
        unique case (r_format)
            FMT_S8:           w_maxv = 31'd127;
            FMT_S16:          w_maxv = 31'd32767;
            FMT_S24, FMT_S32: w_maxv = MAX_Q31;
            default:          w_maxv = '0;
        endcase
    end

    assign w_ip = 62'(w_maxv) * 62'(r_s_mag);

    always_comb begin
        w_pos = '0;
        for (int b = 0; b < 31; b++) begin
            if (r_s_mag[b]) w_pos = 5'(b);
        end
    end

    // Normalized so the leading one sits at bit 30; low bits give the rounding.
    assign w_norm = r_f1_mag << (5'd30 - r_f1_pos);
    assign w_int  = r_f1_neg ? (32'd0 - {1'b0, r_f1_m}) : {1'b0, r_f1_m};

    assign w_mant25 = {1'b0, r_f2_mant} + {24'd0, r_f2_rnd};
    assign w_exp    = 8'(r_f2_pos) + (w_mant25[24] ? 8'd97 : 8'd96);
    assign w_frac   = w_mant25[24] ? 23'd0 : w_mant25[22:0];
    assign w_flt    = r_f2_zero ? 32'd0 : {r_f2_neg, w_exp, w_frac};

    always_comb begin
        unique case (r_format)
            FMT_S8:  w_word = {24'd0, r_f2_int[7:0]};
            FMT_S16: w_word = {16'd0, r_f2_int[15:0]};
            FMT_S24: w_word = {8'd0, r_f2_int[31:8]};
            FMT_S32: w_word = r_f2_int;
            FMT_F32: w_word = w_flt;
            default: w_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_adv) begin
            r_f1_v <= r_s_v;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_m    <= w_ip[61:31];
            r_f1_mag  <= r_s_mag;
            r_f1_pos  <= w_pos;
            r_f1_neg  <= r_s_neg;
            r_f2_int  <= w_int;
            r_f2_mant <= w_norm[30:7];
            r_f2_rnd  <= w_norm[6] && ((|w_norm[5:0]) || w_norm[7]);
            r_f2_pos  <= r_f1_pos;
            r_f2_neg  <= r_f1_neg;
            r_f2_zero <= (r_f1_mag == '0);
            r_f3_word <= w_word;
        end
    end

    // ---------------- Channel copies ---------------------------------------
    logic          r_o_v;
    logic [31:0]   r_o_word;
    logic [CW-1:0] r_o_ch;
    logic          w_o_last;

    assign w_o_last = ({1'b0, r_o_ch} + 1'b1) == {1'b0, w_chans};
    // The output is free once its last copy leaves; an item with no channels
    // is taken and dropped.
    assign w_free   = !r_o_v || (m_axis_tready && w_o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_free) begin
            r_o_v <= r_f3_v && (w_chans != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_o_word <= r_f3_word;
            r_o_ch   <= '0;
        end else if (m_axis_tready) begin
            r_o_ch   <= r_o_ch + 1'b1;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_word;
    assign m_axis_tuser  = CHAN_W'(r_o_ch);
    assign m_axis_tlast  = w_o_last;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Sine tone PCM generator testbench
// Sends sample positions under a range of period, format and channel
// settings, predicts every channel copy in Q1.31 fixed point and checks each
// output item in order, with random gaps and stalls on both stream sides.
// ============================================================================
module testbench;
    import stpg_pkg::*;

    localparam int MAX_CH    = 8;
    localparam int MAX_PER   = 65536;
    localparam int SETTLE    = 60;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [CHAN_W-1:0] chan;
        logic              last;
    } t_copy;

    typedef struct {
        int unsigned per;
        int unsigned fmt;
        int unsigned chans;
        int unsigned idx;
        bit          known;
        logic [31:0] word;
    } t_vec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IDX_W-1:0]      s_axis_tdata;   // [15:0] sample_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [WORD_W-1:0]     m_axis_tdata;   // [31:0] sample_word
    logic [CHAN_W-1:0]     m_axis_tuser;   // [2:0] channel
    logic                  m_axis_tlast;

    t_copy       pending_copies[$];
    int unsigned cur_per, cur_fmt, cur_chans;
    int          err_count;
    int unsigned cycles;
    bit          no_idle;

    sine_tone_pcm_generator_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Magnitude of the sine in Q1.31, with the sign returned separately.
    function automatic bit [31:0] sine_mag(input bit [31:0] phase, output bit neg);
        bit [63:0] frac, a, x, x2, t, s;
        int        k;
        frac = {34'd0, phase[29:0]};
        a = phase[30] ? (64'd1 << 30) - frac : frac;
        x = (a * 64'hC90FDAA2) >> 30;
        x2 = (x * x) >> 31;
        t = 64'h80000000;
        for (k = 14; k >= 2; k -= 2)
            t = 64'h80000000 - (((x2 * t) >> 31) / (k * (k + 1)));
        s = (x * t) >> 31;
        if (s > 64'h7FFFFFFF)
            s = 64'h7FFFFFFF;
        neg = phase[31] && (s != 0);
        return s[31:0];
    endfunction

    function automatic bit [31:0] scaled(input bit [31:0] mag, input bit neg,
                                         input bit [63:0] maxv);
        bit [31:0] m;
        m = 32'((maxv * mag) >> 31);
        return neg ? -m : m;
    endfunction

    function automatic bit [31:0] float_bits(input bit [31:0] mag, input bit neg);
        bit [31:0] p, mant, sh, rem, half;
        if (mag == 0)
            return 32'd0;
        p = 0;
        while (p < 31 && (mag >> (p + 1)) != 0)
            p++;
        if (p <= 23) begin
            mant = mag << (23 - p);
        end else begin
            sh = p - 23;
            mant = mag >> sh;
            rem = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == (32'd1 << 24)) begin
                mant >>= 1;
                p++;
            end
        end
        return {neg, 8'(p + 96), mant[22:0]};
    endfunction

    function automatic bit [31:0] tone_word(input int unsigned idx);
        bit [63:0] per, phase;
        bit [31:0] mag;
        bit        neg;
        per = (cur_per > MAX_PER) ? MAX_PER : cur_per;
        phase = (per != 0) ? ((64'(idx) << 32) / per) : 64'd0;
        mag = sine_mag(phase[31:0], neg);
        unique case (3'(cur_fmt))
            FMT_S8:  return scaled(mag, neg, 127) & 32'hFF;
            FMT_S16: return scaled(mag, neg, 32767) & 32'hFFFF;
            FMT_S24: return scaled(mag, neg, 64'h7FFFFFFF) >> 8;
            FMT_S32: return scaled(mag, neg, 64'h7FFFFFFF);
            FMT_F32: return float_bits(mag, neg);
            default: return 32'd0;
        endcase
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
    endtask

    // Registers change only once the pipeline has drained.
    task automatic apply_config(input int unsigned per, input int unsigned fmt,
                                input int unsigned chans);
        if (per == cur_per && fmt == cur_fmt && chans == cur_chans)
            return;
        s_axis_tvalid <= 1'b0;
        while (pending_copies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (per != cur_per)
            write_reg(CFG_PERIOD, per);
        if (fmt != cur_fmt)
            write_reg(CFG_FORMAT, fmt);
        if (chans != cur_chans)
            write_reg(CFG_CHANS, chans);
        i_cfg_we <= 1'b0;
        cur_per = per;
        cur_fmt = fmt;
        cur_chans = chans;
    endtask

    task automatic send_item(input int unsigned idx, input bit known,
                             input logic [31:0] typed_word);
        int        n, c, g;
        t_copy     cp;
        bit [31:0] w;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IDX_W'(idx);
        do @(posedge i_clk); while (!s_axis_tready);
        w = known ? typed_word : tone_word(idx);
        n = (cur_chans > MAX_CH) ? MAX_CH : cur_chans;
        for (c = 0; c < n; c++) begin
            cp.word = w;
            cp.chan = CHAN_W'(c);
            cp.last = (c + 1 == n);
            pending_copies.insert(pending_copies.size(), cp);
        end
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    t_vec directed [25] = '{
        '{480, FMT_S16, 2, 0, 1, 32'd0},
        '{480, FMT_S16, 2, 120, 0, 0},
        '{480, FMT_S16, 2, 360, 0, 0},
        '{480, FMT_S16, 2, 65535, 0, 0},
        '{480, FMT_S8, 1, 0, 1, 32'd0},
        '{480, FMT_S8, 1, 120, 0, 0},
        '{480, FMT_S8, 1, 360, 0, 0},
        '{480, FMT_S24, 3, 0, 1, 32'd0},
        '{480, FMT_S24, 3, 360, 0, 0},
        '{480, FMT_S32, 4, 0, 1, 32'd0},
        '{480, FMT_S32, 4, 360, 0, 0},
        '{480, FMT_F32, 5, 0, 1, 32'd0},
        '{480, FMT_F32, 5, 100, 0, 0},
        '{480, FMT_F32, 5, 360, 0, 0},
        '{480, 7, 8, 77, 1, 32'd0},
        '{480, 5, 8, 300, 1, 32'd0},
        '{0, FMT_S32, 8, 65535, 1, 32'd0},
        '{1, FMT_S32, 8, 0, 1, 32'd0},
        '{65536, FMT_S32, 1, 16384, 0, 0},
        '{65536, FMT_F32, 1, 49152, 0, 0},
        '{131071, FMT_F32, 15, 65535, 0, 0},
        '{131071, FMT_S16, 15, 16384, 0, 0},
        '{480, FMT_S16, 0, 5, 0, 0},
        '{480, FMT_S16, 0, 120, 0, 0},
        '{2, FMT_S8, 8, 1, 0, 0}
    };

    initial begin
        int unsigned per, fmt, chans, idx, lim;
        int          ph, k;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        err_count     = 0;
        no_idle       = 1'b0;
        cur_per       = 480;
        cur_fmt       = 1;
        cur_chans     = 2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            apply_config(directed[i].per, directed[i].fmt, directed[i].chans);
            send_item(directed[i].idx, directed[i].known, directed[i].word);
        end

        for (ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 5))
                0: per = 1;
                1: per = 2;
                2: per = MAX_PER;
                3: per = $urandom_range(MAX_PER + 1, 131071);
                default: per = $urandom_range(3, 4000);
            endcase
            fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            chans = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            if (ph == 5)
                chans = 0;
            apply_config(per, fmt, chans);
            no_idle = (ph % 3 == 1);
            lim = (per > MAX_PER) ? MAX_PER : per;
            for (k = 0; k < 30; k++) begin
                // Mostly positions inside the period, some anywhere.
                if ($urandom_range(0, 3) == 0 || lim == 0)
                    idx = $urandom_range(0, 65535);
                else
                    idx = $urandom_range(0, lim - 1);
                send_item(idx, 1'b0, 32'd0);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_copies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0)
            $display("** sine_tone_pcm_generator_unit: PASSED **");
        else
            $display("** sine_tone_pcm_generator_unit: FAILED **");
        $finish;
    end

    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_copy want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_copies.size() == 0) begin
                $display("%0t: unexpected item word=%h chan=%0d last=%b", $realtime,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                want = pending_copies.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.chan
                        || m_axis_tlast !== want.last) begin
                    $display("%0t: expected word=%h chan=%0d last=%b, got word=%h chan=%0d last=%b",
                             $realtime, want.word, want.chan, want.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("%0t: timeout, %0d items still expected", $realtime,
                     pending_copies.size());
            $display("** sine_tone_pcm_generator_unit: FAILED **");
            $finish;
        end
    end

    initial cycles = 0;

endmodule

// ===== filelist.f =====
src/stpg_pkg.sv
src/sine_tone_pcm_generator_unit.sv
verif/testbench.sv
